/* rtl/rcc_pkg.sv */
// Shared types, constants and calendar helpers for the real-time clock calendar.
`default_nettype none

package rcc_pkg;

  localparam int unsigned RCC_DEFAULT_SYNC_INTERVAL = 3600;

  // Item kinds.
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_SET  = 2'd1;
  localparam logic [1:0] KIND_LOAD = 2'd2;

  // Sync request codes.
  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_PUSH  = 2'd1;
  localparam logic [1:0] REQ_FETCH = 2'd2;

  // Register indexes.
  localparam logic REG_TWELVE_HOUR   = 1'b0;
  localparam logic REG_SYNC_INTERVAL = 1'b1;

  localparam logic [5:0] SEC_MAX    = 6'd59;
  localparam logic [5:0] MIN_MAX    = 6'd59;
  localparam logic [4:0] HOUR_MAX24 = 5'd23;
  localparam logic [4:0] HOUR_NOON  = 5'd12;
  localparam logic [3:0] MONTH_MAX  = 4'd12;
  localparam logic [6:0] YEAR_MAX   = 7'd99;

  typedef struct packed {
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    logic        pm_flag;
    logic [4:0]  day_of_month;
    logic [3:0]  month_num;
    logic [6:0]  year_num;
    logic [15:0] sync_countdown;
    logic        push_pending;
  } rcc_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] second_in;
    logic [5:0] minute_in;
    logic [4:0] hour_in;
    logic [4:0] day_in;
    logic [3:0] month_in;
    logic [6:0] year_in;
    logic       pm_in;
  } rcc_item_t;

  // Days in a month; every year divisible by four is a leap year in this century.
  function automatic logic [4:0] month_length(input logic [3:0] month,
                                              input logic [6:0] year);
    logic [4:0] len;
    begin
      case (month)
        4'd2:                        len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:     len = 5'd30;
        default:                     len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/rtc_calendar_counter_top.sv */
// Top level of the real-time clock calendar: register port, item pipeline, result register.
//
//   Channel   Handshake                    Beat contents
//   input     in_valid_i / in_ready_o      kind, time and date fields, pm flag
//   output    out_valid_o / out_ready_i    time and date, pm flag, sync request
//   config    psel/penable/pwrite, pready  twelve_hour at 0x0, sync_interval at 0x4
//
// Every item passes from acceptance through the input register, then through the
// next-state logic into the state and result registers.
// A new item is accepted every cycle while results are taken.
// Reset brings the clock to 00:00:00 on day 1, month 1, year 0 with a countdown of one.
// A stalled result holds the pipeline; the input register still takes one more beat.
`default_nettype none

module rtc_calendar_counter_top
  import rcc_pkg::*;
#(
  parameter int unsigned DEFAULT_SYNC_INTERVAL = RCC_DEFAULT_SYNC_INTERVAL
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [5:0]  second_in_i,
  input  logic [5:0]  minute_in_i,
  input  logic [4:0]  hour_in_i,
  input  logic [4:0]  day_in_i,
  input  logic [3:0]  month_in_i,
  input  logic [6:0]  year_in_i,
  input  logic        pm_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  second_out_o,
  output logic [5:0]  minute_out_o,
  output logic [4:0]  hour_out_o,
  output logic        pm_out_o,
  output logic [4:0]  day_out_o,
  output logic [3:0]  month_out_o,
  output logic [6:0]  year_out_o,
  output logic [1:0]  sync_request_o
);

  logic        twelve_hour_q;
  logic [15:0] sync_interval_q;
  logic        cfg_write;
  logic [15:0] sync_reload;

  logic        item_valid_q;
  rcc_item_t   item_q;
  logic        item_advance;

  rcc_state_t  state_q;
  rcc_state_t  state_d;
  logic [1:0]  req_d;

  logic        out_valid_q;
  rcc_state_t  out_state_q;
  logic        out_pm_q;
  logic [1:0]  out_req_q;

  // Register port.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      twelve_hour_q   <= 1'b0;
      sync_interval_q <= 16'd0;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_TWELVE_HOUR:   twelve_hour_q   <= pwdata[0];
        REG_SYNC_INTERVAL: sync_interval_q <= pwdata[15:0];
        default:           twelve_hour_q   <= twelve_hour_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TWELVE_HOUR:   prdata = {31'd0, twelve_hour_q};
      REG_SYNC_INTERVAL: prdata = {16'd0, sync_interval_q};
      default:           prdata = 32'd0;
    endcase
  end

  assign sync_reload = (sync_interval_q == 16'd0) ? 16'(DEFAULT_SYNC_INTERVAL)
                                                 : sync_interval_q;

  // Input register.
  assign item_advance = item_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o   = ~item_valid_q | item_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.kind      <= kind_i;
      item_q.second_in <= second_in_i;
      item_q.minute_in <= minute_in_i;
      item_q.hour_in   <= hour_in_i;
      item_q.day_in    <= day_in_i;
      item_q.month_in  <= month_in_i;
      item_q.year_in   <= year_in_i;
      item_q.pm_in     <= pm_in_i;
    end
  end

  rcc_step u_step (
    .state_i        (state_q),
    .item_i         (item_q),
    .twelve_hour_i  (twelve_hour_q),
    .sync_reload_i  (sync_reload),
    .state_o        (state_d),
    .sync_request_o (req_d)
  );

  // Clock state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.seconds        <= 6'd0;
      state_q.minutes        <= 6'd0;
      state_q.hours          <= 5'd0;
      state_q.pm_flag        <= 1'b0;
      state_q.day_of_month   <= 5'd1;
      state_q.month_num      <= 4'd1;
      state_q.year_num       <= 7'd0;
      state_q.sync_countdown <= 16'd1;
      state_q.push_pending   <= 1'b0;
    end else if (item_advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (item_advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_advance) begin
      out_state_q <= state_d;
      out_pm_q    <= twelve_hour_q & state_d.pm_flag;
      out_req_q   <= req_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign second_out_o   = out_state_q.seconds;
  assign minute_out_o   = out_state_q.minutes;
  assign hour_out_o     = out_state_q.hours;
  assign pm_out_o       = out_pm_q;
  assign day_out_o      = out_state_q.day_of_month;
  assign month_out_o    = out_state_q.month_num;
  assign year_out_o     = out_state_q.year_num;
  assign sync_request_o = out_req_q;

endmodule

`default_nettype wire

/* rtl/rcc_step.sv */
// Next-state logic for one item: tick, set or external load.
`default_nettype none

module rcc_step
  import rcc_pkg::*;
(
  input  rcc_state_t  state_i,
  input  rcc_item_t   item_i,
  input  logic        twelve_hour_i,
  input  logic [15:0] sync_reload_i,
  output rcc_state_t  state_o,
  output logic [1:0]  sync_request_o
);

  rcc_state_t st;
  logic [1:0] req;
  logic [6:0] sec_inc;
  logic [6:0] min_inc;
  logic [5:0] hour_inc;
  logic [5:0] day_inc;
  logic [4:0] mon_inc;
  logic [7:0] year_inc;
  logic       day_step;
  logic       hours_ok;

  always_comb begin
    st       = state_i;
    req      = REQ_NONE;
    day_step = 1'b0;
    sec_inc  = {1'b0, state_i.seconds} + 7'd1;
    min_inc  = {1'b0, state_i.minutes} + 7'd1;
    hour_inc = {1'b0, state_i.hours} + 6'd1;
    day_inc  = {1'b0, state_i.day_of_month} + 6'd1;
    mon_inc  = {1'b0, state_i.month_num} + 5'd1;
    year_inc = {1'b0, state_i.year_num} + 8'd1;
    hours_ok = twelve_hour_i ? (item_i.hour_in >= 5'd1 && item_i.hour_in <= HOUR_NOON)
                             : (item_i.hour_in <= HOUR_MAX24);

    case (item_i.kind)
      KIND_TICK: begin
        if (state_i.push_pending) begin
          st.push_pending = 1'b0;
          req = REQ_PUSH;
        end else if (state_i.sync_countdown == 16'd0) begin
          st.sync_countdown = sync_reload_i;
          req = REQ_FETCH;
        end else if (sec_inc <= {1'b0, SEC_MAX}) begin
          st.seconds = sec_inc[5:0];
        end else begin
          st.seconds = 6'd0;
          if (min_inc <= {1'b0, MIN_MAX}) begin
            st.minutes = min_inc[5:0];
          end else begin
            st.minutes = 6'd0;
            if (twelve_hour_i) begin
              if (hour_inc == {1'b0, HOUR_NOON}) begin
                st.hours = hour_inc[4:0];
                st.pm_flag = ~state_i.pm_flag;
                // Rolling from PM back to AM starts the next day.
                day_step = state_i.pm_flag;
              end else if (hour_inc > {1'b0, HOUR_NOON}) begin
                st.hours = 5'd1;
              end else begin
                st.hours = hour_inc[4:0];
              end
            end else if (hour_inc > {1'b0, HOUR_MAX24}) begin
              st.hours = 5'd0;
              day_step = 1'b1;
            end else begin
              st.hours = hour_inc[4:0];
            end
          end
        end

        if (day_step) begin
          if (day_inc > {1'b0, month_length(state_i.month_num, state_i.year_num)}) begin
            st.day_of_month = 5'd1;
            if (mon_inc > {1'b0, MONTH_MAX}) begin
              st.month_num = 4'd1;
              st.year_num = (year_inc > {1'b0, YEAR_MAX}) ? 7'd0 : year_inc[6:0];
            end else begin
              st.month_num = mon_inc[3:0];
            end
          end else begin
            st.day_of_month = day_inc[4:0];
          end
        end

        if (st.sync_countdown != 16'd0) begin
          st.sync_countdown = st.sync_countdown - 16'd1;
        end
      end
      KIND_SET, KIND_LOAD: begin
        if (item_i.second_in <= SEC_MAX) st.seconds = item_i.second_in;
        if (item_i.minute_in <= MIN_MAX) st.minutes = item_i.minute_in;
        if (hours_ok) st.hours = item_i.hour_in;
        if (item_i.year_in <= YEAR_MAX) st.year_num = item_i.year_in;
        if (item_i.month_in >= 4'd1 && item_i.month_in <= MONTH_MAX) begin
          st.month_num = item_i.month_in;
        end
        // The day is checked against the month and year as just written.
        if (item_i.day_in >= 5'd1 &&
            item_i.day_in <= month_length(st.month_num, st.year_num)) begin
          st.day_of_month = item_i.day_in;
        end
        if (item_i.kind == KIND_SET) begin
          st.push_pending = 1'b1;
        end else begin
          st.pm_flag = twelve_hour_i & item_i.pm_in;
        end
      end
      default: begin
        st = state_i;
      end
    endcase
  end

  assign state_o        = st;
  assign sync_request_o = req;

endmodule

`default_nettype wire

/* rtl/rcc_checker.sv */
// Port-level checks for the real-time clock calendar, bound to the top level.
`default_nettype none

module rcc_checker
  import rcc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [5:0] second_out_o,
  input logic [5:0] minute_out_o,
  input logic [4:0] hour_out_o,
  input logic [4:0] day_out_o,
  input logic [3:0] month_out_o,
  input logic [6:0] year_out_o,
  input logic [1:0] sync_request_o
);

  // A stalled result beat stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // The time of day never leaves its range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> second_out_o <= SEC_MAX && minute_out_o <= MIN_MAX &&
                    hour_out_o <= HOUR_MAX24)
    else $error("time of day out of range");

  // The month and year never leave their range and the day is never zero, whatever was written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> month_out_o >= 4'd1 && month_out_o <= MONTH_MAX &&
                    day_out_o != 5'd0 && year_out_o <= YEAR_MAX)
    else $error("date out of range");

  // Only the three defined sync codes appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sync_request_o == REQ_NONE || sync_request_o == REQ_PUSH ||
                    sync_request_o == REQ_FETCH)
    else $error("undefined sync request code");

endmodule

bind rtc_calendar_counter_top rcc_checker u_rcc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .second_out_o   (second_out_o),
  .minute_out_o   (minute_out_o),
  .hour_out_o     (hour_out_o),
  .day_out_o      (day_out_o),
  .month_out_o    (month_out_o),
  .year_out_o     (year_out_o),
  .sync_request_o (sync_request_o)
);

`default_nettype wire
